>>> hdl/mhfs_pkg.sv
// Shared definitions for the mail header field sanitizer: the store depth,
// character codes, byte classification helpers, the chain control group and
// the controller state type. No dependencies.
`default_nettype none

package mhfs_pkg;

  // Number of cells in the held-whitespace chain (at least 3).
  localparam int HOLD_DEPTH = 32;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_DEL = 8'h7F;

  typedef struct packed {
    logic shift;   // every cell takes its right neighbour's contents
    logic append;  // the new byte lands at the tail of the run
    logic clear;   // the whole run is dropped
  } chain_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DRAIN = 4'b0010,
    ST_OVF   = 4'b0100,
    ST_MARK  = 4'b1000
  } state_e;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SP) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_SP) || (b == CH_TAB);
  endfunction

  function automatic logic [7:0] clean(input logic [7:0] b);
    return ((b < CH_SP) || (b == CH_DEL)) ? CH_SP : b;
  endfunction

endpackage

`default_nettype wire

>>> hdl/mhfs_cell.sv
// One cell of the held-whitespace chain: a byte and an occupied flag.
// Depends on mhfs_pkg for the chain control group.
`default_nettype none

module mhfs_cell (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire mhfs_pkg::chain_ctrl_t ctrl_i,
  input  wire logic [7:0]           new_byte_i,
  input  wire logic                 left_vld_i,
  input  wire logic                 right_vld_i,
  input  wire logic [7:0]           right_byte_i,
  output logic                      vld_o,
  output logic [7:0]                byte_o
);
  import mhfs_pkg::*;

  logic       vld_q, vld_d;
  logic [7:0] byte_q, byte_d;
  logic       take_new;

  // The tail is the last occupied cell after a shift, or the first free one
  // without a shift.
  always_comb begin
    take_new = ctrl_i.append &
               (ctrl_i.shift ? (vld_q & ~right_vld_i) : (~vld_q & left_vld_i));
    if (ctrl_i.clear) begin
      vld_d = 1'b0;
    end else if (take_new) begin
      vld_d = 1'b1;
    end else if (ctrl_i.shift) begin
      vld_d = right_vld_i;
    end else begin
      vld_d = vld_q;
    end
    if (take_new) begin
      byte_d = new_byte_i;
    end else if (ctrl_i.shift) begin
      byte_d = right_byte_i;
    end else begin
      byte_d = byte_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign vld_o  = vld_q;
  assign byte_o = byte_q;

endmodule

`default_nettype wire

>>> hdl/mhfs_chain.sv
// Row of mhfs_cell instances holding the whitespace run, oldest at cell 0.
// Exposes the three front cells for fold detection. Depends on mhfs_pkg.
`default_nettype none

module mhfs_chain (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire mhfs_pkg::chain_ctrl_t ctrl_i,
  input  wire logic [7:0]            new_byte_i,
  output logic [2:0][7:0]            head_byte_o,
  output logic [2:0]                 head_vld_o,
  output logic                       full_o
);
  import mhfs_pkg::*;

  logic       vld  [HOLD_DEPTH];
  logic [7:0] data [HOLD_DEPTH];

  for (genvar i = 0; i < HOLD_DEPTH; i++) begin : g_cell
    logic       left_vld;
    logic       right_vld;
    logic [7:0] right_byte;

    if (i == 0) begin : g_first
      assign left_vld = 1'b1;
    end else begin : g_mid
      assign left_vld = vld[i-1];
    end

    if (i == HOLD_DEPTH - 1) begin : g_last
      assign right_vld  = 1'b0;
      assign right_byte = CH_NUL;
    end else begin : g_inner
      assign right_vld  = vld[i+1];
      assign right_byte = data[i+1];
    end

    mhfs_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl_i),
      .new_byte_i   (new_byte_i),
      .left_vld_i   (left_vld),
      .right_vld_i  (right_vld),
      .right_byte_i (right_byte),
      .vld_o        (vld[i]),
      .byte_o       (data[i])
    );
  end

  for (genvar h = 0; h < 3; h++) begin : g_head
    assign head_byte_o[h] = data[h];
    assign head_vld_o[h]  = vld[h];
  end

  assign full_o = vld[HOLD_DEPTH-1];

endmodule

`default_nettype wire

>>> hdl/mail_header_field_sanitizer.sv
// Top level of the mail header field sanitizer: controller, output register
// and the held-whitespace chain. Depends on mhfs_pkg, mhfs_chain, mhfs_cell.
//
//   channel | handshake               | payload
//   --------+-------------------------+------------------------------------------
//   in      | in_valid_i / in_ready_o | in_byte_i, last_byte_i
//   out     | out_valid_o/out_ready_i | out_byte_o, byte_valid_o, run_last_o,
//           |                         | string_end_o, overflow_o
//
// A whitespace byte that fits in the store is taken back to back. Output stalls
// hold the controller. A non-whitespace byte follows the held bytes, which the
// chain hands to the output register one byte a cycle while the output is free;
// a whitespace byte that meets a full store pushes out the front byte first.
// After reset the store is empty and the block is ready at once.
`default_nettype none

module mail_header_field_sanitizer (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       last_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            byte_valid_o,
  output logic            run_last_o,
  output logic            string_end_o,
  output logic            overflow_o
);
  import mhfs_pkg::*;

  state_e      state_q, state_d;
  logic        fold_keep_q, fold_keep_d;
  logic        fold_lf_q, fold_lf_d;
  logic [7:0]  pend_q, pend_d;
  logic        pend_last_q, pend_last_d;

  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic        byte_valid_q, byte_valid_d;
  logic        run_last_q, run_last_d;
  logic        string_end_q, string_end_d;
  logic        overflow_q, overflow_d;

  chain_ctrl_t     ctrl;
  logic [7:0]      new_byte;
  logic [2:0][7:0] head_byte;
  logic [2:0]      head_vld;
  logic            full;

  logic       in_acc;
  logic       out_free;
  logic [7:0] in_norm;
  logic       fold_start;
  logic [7:0] e_byte;
  logic       e_fold_cr;
  logic       e_keep;
  logic       e_lf;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_q | out_ready_i;
  assign in_norm    = (in_byte_i == CH_NUL) ? CH_SP : in_byte_i;
  assign new_byte   = (state_q == ST_IDLE) ? in_norm : pend_q;

  // A fold is CR LF followed by a blank, all three already held.
  assign fold_start = (head_byte[0] == CH_CR) && (head_byte[1] == CH_LF) &&
                      head_vld[1] && head_vld[2] && is_blank(head_byte[2]);

  // Cleaning of the byte at the front of the chain.
  always_comb begin
    e_fold_cr = 1'b0;
    e_keep    = fold_keep_q;
    e_lf      = 1'b0;
    if (fold_lf_q) begin
      e_byte = head_byte[0];
    end else if (fold_start) begin
      e_byte    = CH_CR;
      e_fold_cr = 1'b1;
      e_keep    = 1'b1;
      e_lf      = 1'b1;
    end else if (fold_keep_q && is_blank(head_byte[0])) begin
      e_byte = head_byte[0];
    end else begin
      e_byte = clean(head_byte[0]);
      e_keep = 1'b0;
    end
  end

  always_comb begin
    state_d      = state_q;
    fold_keep_d  = fold_keep_q;
    fold_lf_d    = fold_lf_q;
    pend_d       = pend_q;
    pend_last_d  = pend_last_q;
    ctrl         = '0;
    out_valid_d  = out_valid_q & ~out_ready_i;
    out_byte_d   = out_byte_q;
    byte_valid_d = byte_valid_q;
    run_last_d   = run_last_q;
    string_end_d = string_end_q;
    overflow_d   = overflow_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          pend_d      = in_norm;
          pend_last_d = last_byte_i;
          if (is_ws(in_norm)) begin
            if (last_byte_i) begin
              ctrl.clear  = 1'b1;
              fold_keep_d = 1'b0;
              fold_lf_d   = 1'b0;
              state_d     = ST_MARK;
            end else if (!full) begin
              ctrl.append = 1'b1;
            end else begin
              state_d = ST_OVF;
            end
          end else begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_MARK: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_byte_d   = CH_NUL;
          byte_valid_d = 1'b0;
          run_last_d   = 1'b1;
          string_end_d = 1'b1;
          overflow_d   = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          byte_valid_d = 1'b1;
          overflow_d   = 1'b0;
          if (head_vld[0]) begin
            out_byte_d   = e_byte;
            run_last_d   = 1'b0;
            string_end_d = 1'b0;
            fold_keep_d  = e_keep;
            fold_lf_d    = e_lf;
            ctrl.shift   = 1'b1;
          end else begin
            out_byte_d   = clean(pend_q);
            run_last_d   = 1'b1;
            string_end_d = pend_last_q;
            fold_keep_d  = 1'b0;
            fold_lf_d    = 1'b0;
            state_d      = ST_IDLE;
          end
        end
      end
      ST_OVF: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          byte_valid_d = 1'b1;
          overflow_d   = 1'b1;
          string_end_d = 1'b0;
          out_byte_d   = e_byte;
          fold_keep_d  = e_keep;
          fold_lf_d    = e_lf;
          ctrl.shift   = 1'b1;
          // The CR of a fold is followed by its LF before the new byte is appended.
          if (e_fold_cr) begin
            run_last_d = 1'b0;
          end else begin
            run_last_d  = 1'b1;
            ctrl.append = 1'b1;
            state_d     = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  mhfs_chain u_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .new_byte_i  (new_byte),
    .head_byte_o (head_byte),
    .head_vld_o  (head_vld),
    .full_o      (full)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fold_keep_q <= 1'b0;
      fold_lf_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fold_keep_q <= fold_keep_d;
      fold_lf_q   <= fold_lf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q       <= pend_d;
    pend_last_q  <= pend_last_d;
    out_byte_q   <= out_byte_d;
    byte_valid_q <= byte_valid_d;
    run_last_q   <= run_last_d;
    string_end_q <= string_end_d;
    overflow_q   <= overflow_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign byte_valid_o = byte_valid_q;
  assign run_last_o   = run_last_q;
  assign string_end_o = string_end_q;
  assign overflow_o   = overflow_q;

  // The LF of a fold must sit at the front of the chain once its CR has gone.
  a_fold_lf_head : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fold_lf_q |-> (head_vld[0] && (head_byte[0] == CH_LF) && fold_keep_q))
    else $error("fold LF not at chain front");

  // An end marker is only pending once the run has been dropped.
  a_mark_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MARK) |-> !head_vld[0])
    else $error("held run not dropped before end marker");

  // The end of a string always closes the results of its item.
  a_end_closes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && string_end_o) |-> run_last_o)
    else $error("string end without run end");

  // A byte that meets a full store leaves the chain full or one short of it.
  a_ovf_refill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(state_q == ST_OVF) && (state_q == ST_IDLE)) |-> head_vld[2])
    else $error("chain emptied by an overflow item");

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for mail_header_field_sanitizer: directed and random header
// fields, with an own predictor of the cleaned byte stream. Depends on mhfs_pkg and
// the RTL under hdl/.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mhfs_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       is_byte;
    logic       run_end;
    logic       str_end;
    logic       ovf;
  } field_result_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] in_byte_i = 8'h00;
  logic       last_byte_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       byte_valid_o;
  logic       run_last_o;
  logic       string_end_o;
  logic       overflow_o;

  // Predictor state: the held whitespace run, oldest first, and the fold flag.
  logic [7:0]    held_q[$];
  bit            after_fold;
  field_result_t expected_q[$];
  logic [7:0]    field_buf[$];

  bit idle_enable = 1'b1;
  int hold_off_left = 0;
  int errors = 0;
  int bytes_sent = 0;
  int fields_sent = 0;
  int results_checked = 0;
  int overflow_results = 0;
  int end_markers = 0;

  mail_header_field_sanitizer u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .last_byte_i  (last_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .run_last_o   (run_last_o),
    .string_end_o (string_end_o),
    .overflow_o   (overflow_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic bit is_space_class(logic [7:0] b);
    return (b == CH_SP) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic bit is_fold_blank(logic [7:0] b);
    return (b == CH_SP) || (b == CH_TAB);
  endfunction

  function automatic logic [7:0] scrub_byte(logic [7:0] b);
    return ((b < CH_SP) || (b == CH_DEL)) ? CH_SP : b;
  endfunction

  function automatic void expect_byte(logic [7:0] b, bit ovf);
    expected_q.push_back('{data: b, is_byte: 1'b1, run_end: 1'b0, str_end: 1'b0, ovf: ovf});
  endfunction

  // Releases the front of the held run: a CR LF that opens a fold goes out as a pair.
  function automatic void release_front(bit ovf);
    logic [7:0] b;
    b = held_q[0];
    if (b == CH_CR && held_q.size() >= 3 && held_q[1] == CH_LF && is_fold_blank(held_q[2])) begin
      expect_byte(CH_CR, ovf);
      expect_byte(CH_LF, ovf);
      after_fold = 1'b1;
      void'(held_q.pop_front());
      void'(held_q.pop_front());
    end else begin
      if (!(after_fold && is_fold_blank(b))) begin
        after_fold = 1'b0;
        b = scrub_byte(b);
      end
      expect_byte(b, ovf);
      void'(held_q.pop_front());
    end
  endfunction

  function automatic void predict_field_byte(logic [7:0] raw, bit last);
    logic [7:0]    b;
    field_result_t tail;
    b = (raw == CH_NUL) ? CH_SP : raw;
    if (is_space_class(b)) begin
      if (last) begin
        held_q.delete();
        after_fold = 1'b0;
        expected_q.push_back('{data: 8'h00, is_byte: 1'b0, run_end: 1'b1, str_end: 1'b1,
                               ovf: 1'b0});
        return;
      end
      held_q.push_back(b);
      if (held_q.size() <= HOLD_DEPTH)
        return;
      release_front(1'b1);
    end else begin
      while (held_q.size() > 0)
        release_front(1'b0);
      after_fold = 1'b0;
      expect_byte(scrub_byte(b), 1'b0);
    end
    tail = expected_q.pop_back();
    tail.run_end = 1'b1;
    tail.str_end = last && !is_space_class(b);
    expected_q.push_back(tail);
  endfunction

  function automatic void check_result();
    field_result_t want;
    if (expected_q.size() == 0) begin
      $error("result with nothing expected: byte %02h valid %0b", out_byte_o, byte_valid_o);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    results_checked++;
    if (want.ovf)
      overflow_results++;
    if (!want.is_byte)
      end_markers++;
    if (out_byte_o !== want.data) begin
      $error("out_byte: expected %02h, got %02h", want.data, out_byte_o);
      errors++;
    end
    if (byte_valid_o !== want.is_byte) begin
      $error("byte_valid: expected %0b, got %0b", want.is_byte, byte_valid_o);
      errors++;
    end
    if (run_last_o !== want.run_end) begin
      $error("run_last: expected %0b, got %0b", want.run_end, run_last_o);
      errors++;
    end
    if (string_end_o !== want.str_end) begin
      $error("string_end: expected %0b, got %0b", want.str_end, string_end_o);
      errors++;
    end
    if (overflow_o !== want.ovf) begin
      $error("overflow: expected %0b, got %0b", want.ovf, overflow_o);
      errors++;
    end
  endfunction

  // Result side: checks every accepted item and drives ready, with the long hold-off
  // counted down here.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        check_result();
      if (hold_off_left > 0) begin
        hold_off_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !(idle_enable && $urandom_range(0, 99) < 11);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit last);
    while (idle_enable && $urandom_range(0, 99) < 11) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    in_byte_i   <= b;
    last_byte_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    predict_field_byte(b, last);
    bytes_sent++;
  endtask

  // Sends the bytes gathered in field_buf as one field, marking the final one.
  task automatic send_field();
    int n;
    n = field_buf.size();
    for (int i = 0; i < n; i++)
      send_byte(field_buf[i], i == n - 1);
    field_buf.delete();
    fields_sent++;
  endtask

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++)
      field_buf.push_back(s[i]);
  endfunction

  function automatic void add_run(logic [7:0] b, int n);
    repeat (n) field_buf.push_back(b);
  endfunction

  // NUL as a space, control bytes, DEL and the top half of the byte range.
  task automatic test_byte_classes();
    field_buf = '{CH_NUL, 8'h41, 8'h01, CH_DEL, 8'h80, 8'hFF, 8'h0B, 8'h62};
    send_field();
  endtask

  // Folds pass unchanged with their blanks; a CR LF without a blank does not.
  task automatic test_folding();
    add_text("x");
    field_buf.push_back(CH_CR);
    field_buf.push_back(CH_LF);
    field_buf.push_back(CH_TAB);
    field_buf.push_back(CH_SP);
    add_text("y");
    field_buf.push_back(CH_CR);
    field_buf.push_back(CH_LF);
    add_text("z");
    field_buf.push_back(CH_CR);
    field_buf.push_back(CH_LF);
    field_buf.push_back(CH_SP);
    field_buf.push_back(CH_CR);
    field_buf.push_back(CH_LF);
    field_buf.push_back(CH_TAB);
    add_text("w");
    send_field();
  endtask

  // Trailing whitespace is dropped and only the end marker comes out.
  task automatic test_string_end();
    field_buf = '{8'h71, CH_SP, CH_TAB, CH_SP};
    send_field();
    field_buf = '{CH_SP};
    send_field();
    field_buf = '{8'h72};
    send_field();
  endtask

  // Runs longer than the store: oldest bytes leave early, a fold at the front as a pair.
  task automatic test_overflow();
    add_text("o");
    field_buf.push_back(CH_CR);
    field_buf.push_back(CH_LF);
    field_buf.push_back(CH_SP);
    add_run(CH_SP, HOLD_DEPTH - 2);
    field_buf.push_back(8'h0C);
    add_text("e");
    send_field();
    add_run(CH_TAB, HOLD_DEPTH + 2);
    send_field();
  endtask

  // The result side holds off for a long while so that the input stalls.
  task automatic test_backpressure();
    hold_off_left = 300;
    for (int i = 0; i < 12; i++)
      field_buf.push_back(8'(8'h61 + (i % 26)));
    send_field();
  endtask

  function automatic logic [7:0] random_space();
    case ($urandom_range(0, 6))
      0: return CH_TAB;
      1: return CH_LF;
      2: return 8'h0B;
      3: return 8'h0C;
      4: return CH_CR;
      5: return CH_NUL;
      default: return CH_SP;
    endcase
  endfunction

  function automatic void add_fold();
    field_buf.push_back(CH_CR);
    field_buf.push_back(CH_LF);
    repeat ($urandom_range(1, 3))
      field_buf.push_back($urandom_range(0, 1) ? CH_SP : CH_TAB);
  endfunction

  // Fields built from words, short runs, folds and the odd long run, plus noise.
  task automatic test_random_fields(input int n_bytes);
    int target;
    int pick;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      repeat ($urandom_range(1, 6)) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          repeat ($urandom_range(1, 6))
            field_buf.push_back($urandom_range(0, 9) == 0 ? 8'($urandom_range(0, 255))
                                                          : 8'($urandom_range(8'h21, 8'h7E)));
        end else if (pick < 70) begin
          repeat ($urandom_range(1, 4)) field_buf.push_back(random_space());
        end else if (pick < 85) begin
          add_fold();
        end else if (pick < 89) begin
          if ($urandom_range(0, 1))
            add_fold();
          repeat ($urandom_range(HOLD_DEPTH - 2, HOLD_DEPTH + 4))
            field_buf.push_back(random_space());
        end else begin
          field_buf.push_back(8'($urandom_range(0, 255)));
        end
      end
      if ($urandom_range(0, 1))
        field_buf.push_back(8'($urandom_range(0, 255)));
      else
        field_buf.push_back(random_space());
      send_field();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_byte_classes();
    test_folding();
    test_string_end();
    test_overflow();
    test_backpressure();
    test_random_fields(12);
    idle_enable = 1'b0;
    test_random_fields(8);
    idle_enable = 1'b1;
    test_random_fields(8);

    in_valid_i <= 1'b0;
    while (expected_q.size() != 0)
      @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (expected_q.size() != 0) begin
      $error("%0d results never arrived", expected_q.size());
      errors++;
    end

    $display("Sent %0d bytes in %0d fields; checked %0d results.",
             bytes_sent, fields_sent, results_checked);
    $display("Among them %0d early overflow bytes and %0d bare end markers.",
             overflow_results, end_markers);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Run did not finish in time.");
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> sim.f
hdl/mhfs_pkg.sv
hdl/mhfs_cell.sv
hdl/mhfs_chain.sv
hdl/mail_header_field_sanitizer.sv
tb/testbench.sv
